FILE: hdl/pn2d_pkg.sv
// pn2d_pkg: shared constants and the elaboration-time sine helper for the
// 2D gradient noise block. Used by pn2d_front, pn2d_back and perlin_noise_2d.
package pn2d_pkg;

  localparam int PN_FRAC_BITS        = 16;
  localparam int PN_ANGLE_TABLE_BITS = 10;
  localparam int PN_QUEUE_DEPTH      = 4;

  localparam logic [31:0] HASH_MUL_A = 32'd3284157443;
  localparam logic [31:0] HASH_MUL_B = 32'd1911520717;
  localparam logic [31:0] HASH_MUL_C = 32'd2048419325;

  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // sin(pi/2 * t), t in Q30, result Q15 rounded; odd Taylor series to degree 13
  function automatic longint pn_quarter_sine(input longint t);
    longint theta;
    longint th2;
    longint acc;
    theta = (t * HALF_PI_Q30) >>> 30;
    th2   = (theta * theta) >>> 30;
    acc   = Q30_ONE;
    acc   = Q30_ONE - ((th2 * acc) >>> 30) / 156;
    acc   = Q30_ONE - ((th2 * acc) >>> 30) / 110;
    acc   = Q30_ONE - ((th2 * acc) >>> 30) / 72;
    acc   = Q30_ONE - ((th2 * acc) >>> 30) / 42;
    acc   = Q30_ONE - ((th2 * acc) >>> 30) / 20;
    acc   = Q30_ONE - ((th2 * acc) >>> 30) / 6;
    return (((acc * theta) >>> 30) + 64'sd16384) >>> 15;
  endfunction

  // quarter-wave table entry k of a full table with 2^tb entries
  function automatic longint pn_sine_entry(input int k, input int tb);
    return pn_quarter_sine(longint'(k) << (32 - tb));
  endfunction

endpackage

FILE: hdl/perlin_noise_2d.sv
// perlin_noise_2d: top level, seed register and front/back hookup.
// Depends on pn2d_pkg, pn2d_front and pn2d_back.
//
// Usage:
//   Input channel in_valid/in_ready carries one point (x_coord, y_coord),
//   unsigned with FRAC_BITS fraction bits. Output channel out_valid/out_ready
//   carries one signed Q1.15 noise_value per point, in order.
//   cfg_wr_en/cfg_wr_data write the noise seed; write it only
//   while no points are in flight.
//   Throughput: one point per cycle while the receiver takes results.
//   A point accepted into the queue passes from the queue into the first
//   of the ten back pipeline stages and on through them to the last, the
//   output register.
//   The 32x32 hash multiplies and the table lookup each take a pipeline stage.
//   When the receiver stalls, the whole back pipeline holds; the four-entry
//   queue keeps taking points until it fills, then in_ready drops.
//   Reset (rst, synchronous) empties queue and pipeline and sets the seed
//   to zero.
module perlin_noise_2d
  import pn2d_pkg::*;
#(
  parameter int FRAC_BITS        = PN_FRAC_BITS,
  parameter int ANGLE_TABLE_BITS = PN_ANGLE_TABLE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        x_coord,
  input  logic [31:0]        y_coord,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] noise_value
);

  logic [31:0] mul_a, mul_b, mul_c;
  logic        q_valid;
  logic        q_ready;
  logic [31:0] q_x, q_y;

  // seeded hash multipliers, held ready-summed
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_a <= HASH_MUL_A;
      mul_b <= HASH_MUL_B;
      mul_c <= HASH_MUL_C;
    end else if (cfg_wr_en) begin
      mul_a <= HASH_MUL_A + cfg_wr_data;
      mul_b <= HASH_MUL_B + cfg_wr_data;
      mul_c <= HASH_MUL_C + cfg_wr_data;
    end
  end

  pn2d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .x_coord  (x_coord),
    .y_coord  (y_coord),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_x      (q_x),
    .q_y      (q_y)
  );

  pn2d_back #(
    .FRAC_BITS        (FRAC_BITS),
    .ANGLE_TABLE_BITS (ANGLE_TABLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .mul_a       (mul_a),
    .mul_b       (mul_b),
    .mul_c       (mul_c),
    .s_valid     (q_valid),
    .s_ready     (q_ready),
    .s_x         (q_x),
    .s_y         (q_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .noise_value (noise_value)
  );

endmodule

FILE: hdl/pn2d_front.sv
// pn2d_front: input acceptance and a short flip-flop queue of points.
// Depends on pn2d_pkg (queue depth).
module pn2d_front
  import pn2d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] x_coord,
  input  logic [31:0] y_coord,
  output logic        q_valid,
  input  logic        q_ready,
  output logic [31:0] q_x,
  output logic [31:0] q_y
);

  localparam int PW = $clog2(PN_QUEUE_DEPTH);
  localparam int CW = $clog2(PN_QUEUE_DEPTH + 1);

  logic [63:0]   mem [PN_QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign in_ready = (count != CW'(PN_QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_x      = mem[rd_ptr][63:32];
  assign q_y      = mem[rd_ptr][31:0];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= {x_coord, y_coord};
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= PW'(wr_ptr + 1'b1);
      if (pop)  rd_ptr <= PW'(rd_ptr + 1'b1);
      if (push && !pop)      count <= CW'(count + 1'b1);
      else if (pop && !push) count <= CW'(count - 1'b1);
    end
  end

endmodule

FILE: hdl/pn2d_back.sv
// pn2d_back: ten-stage noise pipeline (hash, gradient lookup, dot products,
// smoothstep blend, saturation) ending in the output register. Depends on pn2d_pkg.
module pn2d_back
  import pn2d_pkg::*;
#(
  parameter int FRAC_BITS        = PN_FRAC_BITS,
  parameter int ANGLE_TABLE_BITS = PN_ANGLE_TABLE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        mul_a,
  input  logic [31:0]        mul_b,
  input  logic [31:0]        mul_c,
  input  logic               s_valid,
  output logic               s_ready,
  input  logic [31:0]        s_x,
  input  logic [31:0]        s_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] noise_value
);

  localparam int F   = FRAC_BITS;
  localparam int TB  = ANGLE_TABLE_BITS;
  localparam int QS  = 1 << (TB - 2);
  localparam int DW  = F + 1;       // corner offset
  localparam int PW  = DW + 17;     // offset * gradient
  localparam int SW  = PW + 1;      // dot sum
  localparam int NW  = 18;          // corner value
  localparam int DFW = NW + 1;      // corner difference
  localparam int WW  = F + 1;       // smoothstep weight
  localparam int BPW = DFW + WW + 1;
  localparam int TW  = 19;          // x-blended value
  localparam int DYW = TW + 1;
  localparam int YPW = DYW + WW + 1;
  localparam int VW  = 21;

  // quarter-wave sine table, built at elaboration
  logic [16:0] sin_rom [QS+1];
  for (genvar gi = 0; gi <= QS; gi++) begin : g_rom
    assign sin_rom[gi] = 17'(pn_sine_entry(gi, TB));
  end

  function automatic logic [31:0] rot16(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  function automatic logic signed [16:0] grad(input logic [TB-1:0] idx);
    logic [TB-2:0] j;
    logic [TB-2:0] k;
    logic [16:0]   mag;
    j   = {1'b0, idx[TB-3:0]};
    k   = idx[TB-2] ? (TB-1)'(QS - j) : j;
    mag = sin_rom[k];
    return idx[TB-1] ? -$signed(mag) : $signed(mag);
  endfunction

  logic        en;
  logic [9:0]  vld;

  // stage registers
  logic [31:0]             p1_a [4];
  logic [31:0]             p1_row [4];
  logic [F-1:0]            p1_fx, p1_fy;
  logic [F-1:0]            p1_s2x, p1_s2y;
  logic [31:0]             p2_a [4];
  logic [31:0]             p2_b [4];
  logic [F-1:0]            p2_fx, p2_fy;
  logic [WW-1:0]           p2_wx, p2_wy;
  logic [31:0]             p3_ang [4];
  logic [F-1:0]            p3_fx, p3_fy;
  logic [WW-1:0]           p3_wx, p3_wy;
  logic signed [16:0]      p4_gx [4];
  logic signed [16:0]      p4_gy [4];
  logic [F-1:0]            p4_fx, p4_fy;
  logic [WW-1:0]           p4_wx, p4_wy;
  logic signed [PW-1:0]    p5_px [4];
  logic signed [PW-1:0]    p5_py [4];
  logic [WW-1:0]           p5_wx, p5_wy;
  logic signed [NW-1:0]    p6_n [4];
  logic [WW-1:0]           p6_wx, p6_wy;
  logic signed [BPW-1:0]   p7_pt, p7_pb;
  logic signed [NW-1:0]    p7_b0, p7_b1;
  logic [WW-1:0]           p7_wy;
  logic signed [TW-1:0]    p8_top, p8_bot;
  logic [WW-1:0]           p8_wy;
  logic signed [YPW-1:0]   p9_py;
  logic signed [TW-1:0]    p9_top;

  // combinational stage inputs
  logic [31:0]             col [4];
  logic [31:0]             row [4];
  logic [2*F-1:0]          sqx, sqy;
  logic [F+1:0]            kx, ky;
  logic [2*F+1:0]          wpx, wpy;
  logic signed [DW-1:0]    dx [4];
  logic signed [DW-1:0]    dy [4];
  logic signed [SW-1:0]    dsum [4];
  logic signed [DFW-1:0]   dft, dfb;
  logic signed [WW:0]      wxs, wys;
  logic signed [DYW-1:0]   dfy;
  logic signed [VW-1:0]    vsum;

  assign en        = !out_valid || out_ready;
  assign s_ready   = en;
  assign out_valid = vld[9];

  always_comb begin
    col[0] = {{F{1'b0}}, s_x[31:F]};
    row[0] = {{F{1'b0}}, s_y[31:F]};
    col[1] = col[0] + 32'd1;
    row[1] = row[0];
    col[2] = col[0];
    row[2] = row[0] + 32'd1;
    col[3] = col[1];
    row[3] = row[2];
    sqx    = {{F{1'b0}}, s_x[F-1:0]} * {{F{1'b0}}, s_x[F-1:0]};
    sqy    = {{F{1'b0}}, s_y[F-1:0]} * {{F{1'b0}}, s_y[F-1:0]};
    kx     = (F+2)'(3 << F) - {1'b0, p1_fx, 1'b0};
    ky     = (F+2)'(3 << F) - {1'b0, p1_fy, 1'b0};
    wpx    = {{F{1'b0}}, kx} * {2'b00, p1_s2x};
    wpy    = {{F{1'b0}}, ky} * {2'b00, p1_s2y};
    for (int c = 0; c < 4; c++) begin
      dx[c]   = c[0] ? $signed({1'b1, p4_fx}) : $signed({1'b0, p4_fx});
      dy[c]   = c[1] ? $signed({1'b1, p4_fy}) : $signed({1'b0, p4_fy});
      dsum[c] = SW'(p5_px[c]) + SW'(p5_py[c]) + SW'(1 << (F - 1));
    end
    dft  = DFW'(p6_n[1]) - DFW'(p6_n[0]);
    dfb  = DFW'(p6_n[3]) - DFW'(p6_n[2]);
    wxs  = $signed({1'b0, p6_wx});
    wys  = $signed({1'b0, p8_wy});
    dfy  = DYW'(p8_bot) - DYW'(p8_top);
    vsum = VW'(p9_top) + VW'(p9_py >>> F);
  end

  // valid chain, whole pipe moves when the output register can take data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[8:0], s_valid};
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      // hash step one, squares of the fractions
      for (int c = 0; c < 4; c++) begin
        p1_a[c]   <= 32'(col[c] * mul_a);
        p1_row[c] <= row[c];
      end
      p1_fx  <= s_x[F-1:0];
      p1_fy  <= s_y[F-1:0];
      p1_s2x <= sqx[2*F-1:F];
      p1_s2y <= sqy[2*F-1:F];
      // hash step two, smoothstep weights
      for (int c = 0; c < 4; c++) begin
        p2_a[c] <= p1_a[c];
        p2_b[c] <= 32'((p1_row[c] ^ rot16(p1_a[c])) * mul_b);
      end
      p2_fx <= p1_fx;
      p2_fy <= p1_fy;
      p2_wx <= wpx[2*F:F];
      p2_wy <= wpy[2*F:F];
      // hash step three: angle
      for (int c = 0; c < 4; c++) begin
        p3_ang[c] <= 32'((p2_a[c] ^ rot16(p2_b[c])) * mul_c);
      end
      p3_fx <= p2_fx;
      p3_fy <= p2_fy;
      p3_wx <= p2_wx;
      p3_wy <= p2_wy;
      // gradient lookup: sin and cos (quarter turn on)
      for (int c = 0; c < 4; c++) begin
        p4_gx[c] <= grad(p3_ang[c][31 -: TB]);
        p4_gy[c] <= grad(TB'(p3_ang[c][31 -: TB] + TB'(QS)));
      end
      p4_fx <= p3_fx;
      p4_fy <= p3_fy;
      p4_wx <= p3_wx;
      p4_wy <= p3_wy;
      // offset times gradient
      for (int c = 0; c < 4; c++) begin
        p5_px[c] <= PW'(dx[c] * p4_gx[c]);
        p5_py[c] <= PW'(dy[c] * p4_gy[c]);
      end
      p5_wx <= p4_wx;
      p5_wy <= p4_wy;
      // dot product rounded to Q15
      for (int c = 0; c < 4; c++) begin
        p6_n[c] <= NW'(dsum[c] >>> F);
      end
      p6_wx <= p5_wx;
      p6_wy <= p5_wy;
      // blend along x: products
      p7_pt <= BPW'(dft * wxs);
      p7_pb <= BPW'(dfb * wxs);
      p7_b0 <= p6_n[0];
      p7_b1 <= p6_n[2];
      p7_wy <= p6_wy;
      // blend along x: sums
      p8_top <= TW'(p7_b0) + TW'(p7_pt >>> F);
      p8_bot <= TW'(p7_b1) + TW'(p7_pb >>> F);
      p8_wy  <= p7_wy;
      // blend along y: product
      p9_py  <= YPW'(dfy * wys);
      p9_top <= p8_top;
      // final sum and saturation
      if (vsum > VW'(32767))       noise_value <= 16'sh7FFF;
      else if (vsum < -VW'(32768)) noise_value <= -16'sh8000;
      else                         noise_value <= vsum[15:0];
    end
  end

endmodule
